>>> rtl/kmmr_pkg.sv
// Package: shared types, constants and command/status structs for the KM median/RMST core.
`timescale 1ns / 1ps
`default_nettype none
package kmmr_pkg;
    localparam int TIME_W       = 32;
    localparam int KEY_W        = TIME_W + 1;
    localparam int SURV_W       = 32;
    localparam int STAT_W       = 48;
    localparam int DVD_W        = 64;
    localparam int DVS_W        = 32;
    localparam int MAX_SUBJ_DEF = 1024;

    localparam logic [SURV_W-1:0] Q_ONE  = 32'h8000_0000;
    localparam logic [SURV_W-1:0] Q_HALF = 32'h4000_0000;

    typedef enum logic [1:0] {
        RC_OK  = 2'd0,
        RC_NR  = 2'd1,
        RC_OVF = 2'd2
    } t_code;

    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_MED  = 2'd1,
        RES_RMST = 2'd2
    } t_res_sel;

    typedef struct packed {
        logic [TIME_W-1:0] subject_time;
        logic              event_flag;
        logic              last_subject;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0] stat_value;
        logic [1:0]        result_code;
    } t_out;

    typedef struct packed {
        logic     load;
        logic     rd_prev;
        logic     shift;
        logic     put;
        logic     scan_init;
        logic     sc_rd;
        logic     grp_start;
        logic     grp_add;
        logic     grp_close;
        logic     div_sp_start;
        logic     sp_upd;
        logic     acc_add;
        logic     div_q_start;
        logic     adv_t;
        logic     med_mul;
        logic     fin_mul;
        logic     set_res;
        t_res_sel res_sel;
        t_code    res_code;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic room;
        logic last;
        logic pos_zero;
        logic gt;
        logic scan_end;
        logic grp_open;
        logic same_t;
        logic ev_nz;
        logic div_done;
        logic sp_lt_half;
        logic mode;
        logic m_nz;
        logic ovf;
        logic out_busy;
    } t_sts;
endpackage
`default_nettype wire

>>> rtl/kaplan_meier_median_rmst_core.sv
// Top level: Kaplan-Meier median / restricted mean survival core.
// Load: each stored entry larger than the new key shifts up one place, then the key is written in.
// Close: subjects are read in order and grouped by time; each distinct event time runs the
// 64-step bit-serial divide, then accumulates; median crossing adds a divide and multiply, RMST a multiply-accumulate.
// Input stalls from load through result hand-off; next group loads while result waits.
// Reset (synchronous, active low) clears mode, count, overflow and valids; no memory clear.
`timescale 1ns / 1ps
`default_nettype none
module kaplan_meier_median_rmst_core
    import kmmr_pkg::*;
#(
    parameter int MAX_SUBJECTS = MAX_SUBJ_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data,
    input  wire logic i_cfg_valid,
    output logic      o_cfg_ready,
    input  wire logic i_cfg_data
);
    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    kmmr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.last_subject),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    kmmr_dp #(
        .MAX_SUBJECTS (MAX_SUBJECTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );
endmodule
`default_nettype wire

>>> rtl/kmmr_div.sv
// Restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module kmmr_div
    import kmmr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DVS_W-1:0]      o_quotient
);
    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W:0]   w_sh;
    logic [DVS_W+1:0] w_diff;

    assign w_sh   = {r_rem, r_dvd[DVD_W-1]};
    assign w_diff = {1'b0, w_sh} - {2'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            if (!w_diff[DVS_W+1]) begin
                r_rem <= w_diff[DVS_W-1:0];
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[DVS_W-1:0];
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd[DVS_W-1:0];
endmodule
`default_nettype wire

>>> rtl/kmmr_ctrl.sv
// Controller: sequences insertion sort on load, curve scan, median/RMST and result transfer.
`timescale 1ns / 1ps
`default_nettype none
module kmmr_ctrl
    import kmmr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_last,
    input  wire t_sts i_sts,
    output logic      o_in_stall,
    output t_cmd      o_cmd
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_INS_RD, ST_INS_CMP, ST_FIN, ST_SC_RD, ST_SC_CHK, ST_GRP_END,
        ST_DIV_SP, ST_ACC, ST_DIV_Q, ST_MED_SUM, ST_FINAL, ST_FIN_ACC, ST_FIN_SUM,
        ST_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.res_sel  = RES_ZERO;
        o_cmd.res_code = RC_OK;
        n_state        = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.room) begin
                        n_state = ST_INS_RD;
                    end else if (i_in_last) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_INS_RD: begin
                if (i_sts.pos_zero) begin
                    o_cmd.put = 1'b1;
                    n_state   = i_sts.last ? ST_FIN : ST_IDLE;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                if (i_sts.gt) begin
                    o_cmd.shift = 1'b1;
                    n_state     = ST_INS_RD;
                end else begin
                    o_cmd.put = 1'b1;
                    n_state   = i_sts.last ? ST_FIN : ST_IDLE;
                end
            end
            ST_FIN: begin
                if (i_sts.ovf) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = RC_OVF;
                    n_state        = ST_OUT;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = ST_SC_RD;
                end
            end
            ST_SC_RD: begin
                if (i_sts.scan_end) begin
                    n_state = ST_GRP_END;
                end else begin
                    o_cmd.sc_rd = 1'b1;
                    n_state     = ST_SC_CHK;
                end
            end
            ST_SC_CHK: begin
                if (!i_sts.grp_open) begin
                    o_cmd.grp_start = 1'b1;
                    n_state         = ST_SC_RD;
                end else if (i_sts.same_t) begin
                    o_cmd.grp_add = 1'b1;
                    n_state       = ST_SC_RD;
                end else begin
                    n_state = ST_GRP_END;
                end
            end
            ST_GRP_END: begin
                o_cmd.grp_close = 1'b1;
                if (i_sts.ev_nz) begin
                    o_cmd.div_sp_start = 1'b1;
                    n_state            = ST_DIV_SP;
                end else begin
                    n_state = i_sts.scan_end ? ST_FINAL : ST_SC_RD;
                end
            end
            ST_DIV_SP: begin
                if (i_sts.div_done) begin
                    o_cmd.sp_upd = 1'b1;
                    n_state      = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.acc_add = 1'b1;
                if (!i_sts.mode && i_sts.sp_lt_half) begin
                    o_cmd.div_q_start = 1'b1;
                    n_state           = ST_DIV_Q;
                end else begin
                    o_cmd.adv_t = 1'b1;
                    n_state     = i_sts.scan_end ? ST_FINAL : ST_SC_RD;
                end
            end
            ST_DIV_Q: begin
                if (i_sts.div_done) begin
                    o_cmd.med_mul = 1'b1;
                    n_state       = ST_MED_SUM;
                end
            end
            ST_MED_SUM: begin
                o_cmd.set_res = 1'b1;
                o_cmd.res_sel = RES_MED;
                n_state       = ST_OUT;
            end
            ST_FINAL: begin
                if (!i_sts.mode) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = RC_NR;
                    n_state        = ST_OUT;
                end else if (!i_sts.m_nz) begin
                    o_cmd.set_res = 1'b1;
                    n_state       = ST_OUT;
                end else begin
                    o_cmd.fin_mul = 1'b1;
                    n_state       = ST_FIN_ACC;
                end
            end
            ST_FIN_ACC: begin
                o_cmd.acc_add = 1'b1;
                n_state       = ST_FIN_SUM;
            end
            ST_FIN_SUM: begin
                o_cmd.set_res = 1'b1;
                o_cmd.res_sel = RES_RMST;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/kmmr_dp.sv
// Datapath: sorted key memory, curve scan registers, divider, multiplier and result register.
`timescale 1ns / 1ps
`default_nettype none
module kmmr_dp
    import kmmr_pkg::*;
#(
    parameter int MAX_SUBJECTS = MAX_SUBJ_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_in_data,
    input  wire logic i_out_stall,
    input  wire logic i_cfg_wr,
    input  wire logic i_cfg_data,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out      o_out_data
);
    localparam int CW = $clog2(MAX_SUBJECTS + 1);
    localparam int AW = $clog2(MAX_SUBJECTS);
    localparam int PW = SURV_W + CW;

    logic [KEY_W-1:0]  r_mem [MAX_SUBJECTS];
    logic [KEY_W-1:0]  r_rd;
    logic [KEY_W-1:0]  r_key;
    logic              r_last;
    logic              r_mode;
    logic              r_ovf;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_pos;
    logic [CW-1:0]     r_i;
    logic [CW-1:0]     r_ar;
    logic [CW-1:0]     r_ev;
    logic              r_open;
    logic [TIME_W-1:0] r_grp_t;
    logic [TIME_W-1:0] r_prev_t;
    logic [SURV_W-1:0] r_sp;
    logic [SURV_W-1:0] r_prev_s;
    logic              r_m_nz;
    logic [63:0]       r_prod;
    logic [63:0]       r_acc;
    logic [STAT_W-1:0] r_res_stat;
    logic [1:0]        r_res_code;
    logic [STAT_W-1:0] r_stat;
    logic [1:0]        r_code;
    logic              r_out_valid;

    logic [CW-1:0]     w_pos_m1;
    logic [AW-1:0]     w_rd_addr;
    logic [TIME_W-1:0] w_rd_t;
    logic [PW-1:0]     w_num;
    logic [TIME_W-1:0] w_dt;
    logic              w_div_start;
    logic [DVD_W-1:0]  w_dvd;
    logic [DVS_W-1:0]  w_dvs;
    logic              w_div_done;
    logic [DVS_W-1:0]  w_quo;
    logic [STAT_W:0]   w_med;
    logic [STAT_W:0]   w_rmst;
    logic [STAT_W-1:0] w_stat;

    assign w_pos_m1  = r_pos - 1'b1;
    assign w_rd_addr = i_cmd.rd_prev ? w_pos_m1[AW-1:0] : r_i[AW-1:0];
    assign w_rd_t    = r_rd[KEY_W-1:1];
    assign w_num     = PW'(r_sp) * PW'(r_ar - r_ev);
    assign w_dt      = r_grp_t - r_prev_t;

    assign w_div_start = i_cmd.div_sp_start | i_cmd.div_q_start;
    assign w_dvd = i_cmd.div_q_start ? {r_prev_s - Q_HALF, 32'b0} : DVD_W'(w_num);
    assign w_dvs = i_cmd.div_q_start ? (r_prev_s - r_sp) : DVS_W'(r_ar);

    kmmr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_med  = {1'b0, r_prev_t, 16'b0} + {1'b0, r_prod[63:16]};
    assign w_rmst = r_acc[63:15];

    always_comb begin
        unique case (i_cmd.res_sel)
            RES_MED:  w_stat = w_med[STAT_W] ? '1 : w_med[STAT_W-1:0];
            RES_RMST: w_stat = w_rmst[STAT_W] ? '1 : w_rmst[STAT_W-1:0];
            default:  w_stat = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_mem[r_pos[AW-1:0]] <= r_key;
        end else if (i_cmd.shift) begin
            r_mem[r_pos[AW-1:0]] <= r_rd;
        end
        if (i_cmd.rd_prev || i_cmd.sc_rd) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_ovf       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_mode <= i_cfg_data;
            end
            if (i_cmd.load && !o_sts.room) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.put) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.emit) begin
                r_count     <= '0;
                r_ovf       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= {i_in_data.subject_time, i_in_data.event_flag};
            r_last <= i_in_data.last_subject;
            r_pos  <= r_count;
        end
        if (i_cmd.shift) begin
            r_pos <= w_pos_m1;
        end
        if (i_cmd.scan_init) begin
            r_i      <= '0;
            r_open   <= 1'b0;
            r_sp     <= Q_ONE;
            r_prev_s <= Q_ONE;
            r_prev_t <= '0;
            r_m_nz   <= 1'b0;
            r_acc    <= '0;
        end
        if (i_cmd.grp_start) begin
            r_grp_t <= w_rd_t;
            r_ar    <= r_count - r_i;
            r_ev    <= CW'(r_rd[0]);
            r_i     <= r_i + 1'b1;
            r_open  <= 1'b1;
        end
        if (i_cmd.grp_add) begin
            r_ev <= r_ev + CW'(r_rd[0]);
            r_i  <= r_i + 1'b1;
        end
        if (i_cmd.grp_close) begin
            r_open <= 1'b0;
        end
        if (i_cmd.sp_upd) begin
            r_prod   <= 64'(r_sp) * 64'(w_dt);
            r_prev_s <= r_sp;
            r_sp     <= w_quo;
            r_m_nz   <= 1'b1;
        end
        if (i_cmd.fin_mul) begin
            r_prod <= 64'(r_sp) * 64'(w_dt);
        end
        if (i_cmd.med_mul) begin
            r_prod <= 64'(w_dt) * 64'(w_quo);
        end
        if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_cmd.adv_t) begin
            r_prev_t <= r_grp_t;
        end
        // result is held here until the output register is free
        if (i_cmd.set_res) begin
            r_res_stat <= w_stat;
            r_res_code <= i_cmd.res_code;
        end
        if (i_cmd.emit) begin
            r_stat <= r_res_stat;
            r_code <= r_res_code;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.room       = (r_count < CW'(MAX_SUBJECTS));
        o_sts.last       = r_last;
        o_sts.pos_zero   = (r_pos == '0);
        o_sts.gt         = (r_rd > r_key);
        o_sts.scan_end   = (r_i == r_count);
        o_sts.grp_open   = r_open;
        o_sts.same_t     = (w_rd_t == r_grp_t);
        o_sts.ev_nz      = (r_ev != '0);
        o_sts.div_done   = w_div_done;
        o_sts.sp_lt_half = (r_sp < Q_HALF);
        o_sts.mode       = r_mode;
        o_sts.m_nz       = r_m_nz;
        o_sts.ovf        = r_ovf;
        o_sts.out_busy   = r_out_valid;
    end

    assign o_out_valid            = r_out_valid;
    assign o_out_data.stat_value  = r_stat;
    assign o_out_data.result_code = r_code;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SUBJECTS))
        else $error("group count above capacity");
    a_emit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_count == '0) && !r_ovf && r_out_valid)
        else $error("group state not cleared after result");
    a_sp_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sp_upd |=> (r_sp <= $past(r_sp)))
        else $error("survival increased");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_out_valid)
        else $error("result overwritten before transfer");
endmodule
`default_nettype wire

>>> test/kaplan_meier_median_rmst_core_tb.sv
// Testbench: random and directed groups against a Kaplan-Meier median/RMST predictor.
`timescale 1ns / 1ps
module kaplan_meier_median_rmst_core_tb;
    import kmmr_pkg::*;

    localparam int CAP      = 1024;
    localparam int HOLD_LEN = 600;

    class survival_scoreboard;
        t_out           expected_q[$];
        logic           mode;
        logic [31:0]    grp_times[$];
        logic           grp_events[$];
        logic           grp_ovf;
        int             errors;

        function new();
            mode = 0;
            grp_ovf = 0;
            errors = 0;
        endfunction

        // Kaplan-Meier curve, then median or restricted mean in Q32.16
        function t_out survival_stat();
            t_out        r;
            logic [32:0] keys[];
            logic [32:0] tmp;
            logic [63:0] cur_t[$];
            logic [63:0] cur_s[$];
            logic [63:0] s, t, p1, p2, t1, dt, q, res, tmax, lo, hi;
            int          n, i, j, k, ar, ev;
            bit          found;
            r.result_code = RC_OK;
            r.stat_value = '0;
            if (grp_ovf) begin
                r.result_code = RC_OVF;
                return r;
            end
            n = grp_times.size();
            keys = new[n];
            for (i = 0; i < n; i++) keys[i] = {grp_times[i], grp_events[i]};
            for (i = 1; i < n; i++) begin
                tmp = keys[i];
                j = i - 1;
                while (j >= 0 && keys[j] > tmp) begin
                    keys[j+1] = keys[j];
                    j--;
                end
                keys[j+1] = tmp;
            end
            s = Q_ONE;
            cur_t = {cur_t, 64'd0};
            cur_s = {cur_s, 64'(Q_ONE)};
            i = 0;
            while (i < n) begin
                t = keys[i][32:1];
                ar = n - i;
                ev = 0;
                j = i;
                while (j < n && keys[j][32:1] == t) begin
                    ev += keys[j][0];
                    j++;
                end
                if (ev > 0) begin
                    s = (s * (ar - ev)) / ar;
                    cur_t = {cur_t, t};
                    cur_s = {cur_s, s};
                end
                i = j;
            end
            res = 0;
            if (mode == 1'b0) begin
                found = 0;
                for (k = 1; k < cur_s.size() && !found; k++) begin
                    if (cur_s[k] < Q_HALF) begin
                        p1 = cur_s[k-1];
                        p2 = cur_s[k];
                        t1 = cur_t[k-1];
                        dt = cur_t[k] - t1;
                        q = ((p1 - Q_HALF) << 32) / (p1 - p2);
                        res = (t1 << 16) + (dt >> 16) * q + (((dt & 64'hFFFF) * q) >> 16);
                        found = 1;
                    end
                end
                if (!found) r.result_code = RC_NR;
            end else if (cur_s.size() > 1) begin
                tmax = keys[n-1][32:1];
                lo = 0;
                hi = 0;
                for (k = 0; k < cur_s.size(); k++) begin
                    dt = (k < cur_s.size() - 1) ? cur_t[k+1] - cur_t[k] : tmax - cur_t[k];
                    lo += cur_s[k] * (dt & 64'hFFFF);
                    hi += cur_s[k] * (dt >> 16);
                end
                res = hi * 2 + (lo >> 15);
            end
            if (res > 64'hFFFF_FFFF_FFFF) res = 64'hFFFF_FFFF_FFFF;
            r.stat_value = res[47:0];
            return r;
        endfunction

        function void note_input(t_in x);
            if (grp_times.size() < CAP) begin
                grp_times = {grp_times, x.subject_time};
                grp_events = {grp_events, x.event_flag};
            end else begin
                grp_ovf = 1;
            end
            if (x.last_subject) begin
                expected_q = {expected_q, survival_stat()};
                grp_times.delete();
                grp_events.delete();
                grp_ovf = 0;
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                $error("unexpected result stat_value=%0h result_code=%0d",
                       got.stat_value, got.result_code);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.stat_value !== want.stat_value) begin
                $error("stat_value: expected %0h, actual %0h", want.stat_value, got.stat_value);
                errors++;
            end
            if (got.result_code !== want.result_code) begin
                $error("result_code: expected %0d, actual %0d",
                       want.result_code, got.result_code);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic i_cfg_data;

    survival_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int hold_token;
    int hold_done;
    int hold_cnt;

    kaplan_meier_median_rmst_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("FAIL");
        $finish;
    end

    // receiver: random stall, long hold on request, result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_done <= 0;
            hold_cnt <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_data);
            if (hold_token != hold_done) begin
                hold_done <= hold_token;
                hold_cnt <= HOLD_LEN;
                i_out_stall <= 1'b1;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    task automatic send_subject(logic [31:0] t, logic ev, logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{subject_time: t, event_flag: ev, last_subject: last};
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(i_in_data);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_mode(logic m);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.mode = m;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_time();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 7);
            1: return $urandom_range(0, 300);
            2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            3: return 32'hFFFF_FFFF - $urandom_range(0, 5);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_group(int n);
        for (int i = 0; i < n; i++)
            send_subject(pick_time(), $urandom_range(0, 2) != 0, i == n - 1);
    endtask

    task automatic random_groups(int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            send_group(n);
            sent += n;
        end
    endtask

    task automatic directed();
        for (int m = 0; m < 2; m++) begin
            write_mode(m[0]);
            send_subject(0, 1, 1);
            send_subject(32'hFFFF_FFFF, 0, 1);
            send_subject(32'hFFFF_FFFF, 1, 0);
            send_subject(0, 0, 1);
            send_subject(5, 1, 0);
            send_subject(5, 1, 0);
            send_subject(5, 0, 0);
            send_subject(9, 1, 1);
            send_subject(1, 1, 0);
            send_subject(32'hFFFF_FFFF, 1, 1);
            send_subject(3, 0, 0);
            send_subject(2, 0, 1);
        end
    endtask

    initial begin
        sb = new();
        idle_pct = 0;
        stall_pct = 0;
        hold_token = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed();

        // capacity: group fills the store, then overflows; ascending times keep loads fast
        write_mode(1'b0);
        for (int i = 0; i < CAP + 3; i++) send_subject(i, 1, i == CAP + 2);

        for (int ph = 0; ph < 8; ph++) begin
            write_mode(ph[0]);
            case (ph / 2)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 49; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            if (ph == 2) hold_token++;
            random_groups(30);
        end
        drain();
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

>>> kaplan_meier_median_rmst_core.f
rtl/kmmr_pkg.sv
rtl/kmmr_div.sv
rtl/kmmr_ctrl.sv
rtl/kmmr_dp.sv
rtl/kaplan_meier_median_rmst_core.sv
test/kaplan_meier_median_rmst_core_tb.sv
